// ===== src/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the stereo bitcrusher mix block.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned SampleBitsDef = 24;
  localparam int unsigned PeakW         = 24;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 25;
  localparam int unsigned LevelsW       = 17;
  localparam int unsigned RecipW        = 24;
  localparam int unsigned StepW         = 25;
  localparam int unsigned DryW          = 8;
  localparam int unsigned RwW           = RecipW + DryW;

  localparam logic [StepW-1:0]   PhaseOne    = 25'h100_0000;
  localparam logic [DryW-1:0]    DryFull     = 8'd128;
  localparam logic [LevelsW-1:0] LevelsReset = 17'd256;
  localparam logic [RecipW-1:0]  RecipReset  = 24'd32768;
  localparam logic [StepW-1:0]   StepReset   = 25'h100_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYPASS = 3'd0,
    CFG_MONO   = 3'd1,
    CFG_LEVELS = 3'd2,
    CFG_RECIP  = 3'd3,
    CFG_STEP   = 3'd4,
    CFG_DRY    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_QUANT = 2'd1,
    ST_SCALE = 2'd2,
    ST_MIX   = 2'd3
  } state_e;

  typedef struct packed {
    logic crush;
    logic upd;
    logic mono;
    logic bypass;
  } ctrl_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic hold;
  } lane_en_t;

endpackage

// ===== src/sbc_lane.sv =====
// ----------------------------------------------------------------------------
// sbc_lane
// One channel: quantise, rescale with wet gain, hold, and add the dry part.
// ----------------------------------------------------------------------------
module sbc_lane #(
  parameter int unsigned SampleBits = sbc_pkg::SampleBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sbc_pkg::lane_en_t                  en_i,
  input  logic signed [SampleBits-1:0]       x_i,
  input  logic [sbc_pkg::LevelsW-1:0]        levels_i,
  input  logic [sbc_pkg::DryW-1:0]           dry_i,
  input  logic [sbc_pkg::RwW-1:0]            rw_i,
  output logic signed [SampleBits-1:0]       x_o,
  output logic signed [SampleBits-1:0]       mix_o
);

  localparam int unsigned P1W  = SampleBits + sbc_pkg::LevelsW + 1;
  localparam int unsigned XdW  = SampleBits + sbc_pkg::DryW + 1;
  localparam int unsigned QW   = P1W - (SampleBits - 1);
  localparam int unsigned P2W  = QW + sbc_pkg::RwW + 1;
  localparam int unsigned HW   = P2W - 7;
  localparam int unsigned DdW  = XdW - 7;
  localparam int unsigned SumW = SampleBits + 3;

  localparam logic [P1W-1:0] P1Bias = {{(P1W - SampleBits + 1){1'b0}}, {(SampleBits - 1){1'b1}}};
  localparam logic [XdW-1:0] XdBias = {{(XdW - 7){1'b0}}, 7'h7f};
  localparam logic [P2W-1:0] P2Bias = {{(P2W - 7){1'b0}}, 7'h7f};
  localparam logic [SampleBits-1:0] SatMax = {1'b0, {(SampleBits - 1){1'b1}}};
  localparam logic [SampleBits-1:0] SatMin = {1'b1, {(SampleBits - 1){1'b0}}};

  logic signed [SampleBits-1:0] x_q;
  logic signed [P1W-1:0]        p1_q;
  logic signed [XdW-1:0]        xd_q;
  logic signed [P2W-1:0]        p2_q;
  logic signed [DdW-1:0]        dd_q;
  logic signed [SampleBits-1:0] held_q;
  logic signed [SampleBits-1:0] held_d;

  logic [P1W-1:0]        p1_sum;
  logic signed [QW-1:0]  q_val;
  logic [XdW-1:0]        xd_sum;
  logic signed [P2W-1:0] p2_d;
  logic [P2W-1:0]        p2_sum;
  logic [HW-1:0]         h_val;
  logic                  h_fits;
  logic signed [SumW-1:0] mix_sum;
  logic                  mix_fits;

  always_comb begin
    p1_sum = p1_q + (p1_q[P1W-1] ? P1Bias : '0);
    q_val  = p1_sum[P1W-1:SampleBits-1];
    p2_d   = P2W'(q_val) * P2W'($signed({1'b0, rw_i}));
    xd_sum = xd_q + (xd_q[XdW-1] ? XdBias : '0);
  end

  always_comb begin
    p2_sum = p2_q + (p2_q[P2W-1] ? P2Bias : '0);
    h_val  = p2_sum[P2W-1:7];
    h_fits = (&h_val[HW-1:SampleBits-1]) | ~(|h_val[HW-1:SampleBits-1]);
    if (h_fits) begin
      held_d = h_val[SampleBits-1:0];
    end else if (h_val[HW-1]) begin
      held_d = SatMin;
    end else begin
      held_d = SatMax;
    end
  end

  always_comb begin
    mix_sum  = SumW'(held_q) + SumW'(dd_q);
    mix_fits = (&mix_sum[SumW-1:SampleBits-1]) | ~(|mix_sum[SumW-1:SampleBits-1]);
    if (mix_fits) begin
      mix_o = mix_sum[SampleBits-1:0];
    end else if (mix_sum[SumW-1]) begin
      mix_o = SatMin;
    end else begin
      mix_o = SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load) begin
      x_q  <= x_i;
      p1_q <= P1W'(x_i) * P1W'($signed({1'b0, levels_i}));
      xd_q <= XdW'(x_i) * XdW'($signed({1'b0, dry_i}));
    end
    if (en_i.scale) begin
      p2_q <= p2_d;
      dd_q <= xd_sum[XdW-1:7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (en_i.hold) begin
      held_q <= held_d;
    end
  end

  assign x_o = x_q;

endmodule

// ===== src/sbc_merge.sv =====
// ----------------------------------------------------------------------------
// sbc_merge
// Combine the lane results by mode, keep the peak meter, register the output.
// ----------------------------------------------------------------------------
module sbc_merge #(
  parameter int unsigned SampleBits = sbc_pkg::SampleBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbc_pkg::ctrl_t                   ctrl_i,
  input  logic                             peak_en_i,
  input  logic signed [SampleBits-1:0]     left_in_i,
  input  logic                             done_i,
  input  logic signed [SampleBits-1:0]     x_l_i,
  input  logic signed [SampleBits-1:0]     x_r_i,
  input  logic signed [SampleBits-1:0]     mix_l_i,
  input  logic signed [SampleBits-1:0]     mix_r_i,
  input  logic                             out_stall_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  output logic signed [SampleBits-1:0]     left_out_o,
  output logic signed [SampleBits-1:0]     right_out_o,
  output logic [sbc_pkg::PeakW-1:0]        peak_level_o
);

  localparam int unsigned CmpW = (SampleBits > sbc_pkg::PeakW) ? SampleBits : sbc_pkg::PeakW;

  logic [sbc_pkg::PeakW-1:0]    peak_q;
  logic [SampleBits-1:0]        mag;
  logic [CmpW-1:0]              mag_ext;
  logic [CmpW-1:0]              peak_ext;

  logic                         out_valid_q;
  logic signed [SampleBits-1:0] left_q;
  logic signed [SampleBits-1:0] right_q;
  logic [sbc_pkg::PeakW-1:0]    peak_out_q;
  logic signed [SampleBits-1:0] left_d;
  logic signed [SampleBits-1:0] right_d;
  logic                         load;

  always_comb begin
    mag      = left_in_i[SampleBits-1] ? SampleBits'(-left_in_i) : SampleBits'(left_in_i);
    mag_ext  = CmpW'(mag);
    peak_ext = CmpW'(peak_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (peak_en_i && (mag_ext > peak_ext)) begin
      peak_q <= sbc_pkg::PeakW'(mag_ext);
    end
  end

  always_comb begin
    if (ctrl_i.mono) begin
      left_d  = x_l_i;
      right_d = '0;
    end else if (ctrl_i.bypass) begin
      left_d  = x_l_i;
      right_d = x_r_i;
    end else begin
      left_d  = mix_l_i;
      right_d = mix_r_i;
    end
  end

  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = done_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q     <= left_d;
      right_q    <= right_d;
      peak_out_q <= peak_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_out_o   = left_q;
  assign right_out_o  = right_q;
  assign peak_level_o = peak_out_q;

endmodule

// ===== src/stereo_bitcrusher_mix_top.sv =====
// Flow: an accepted request passes the quantise, scale and mix steps before its result
// reaches the outputs; no new request is taken until that result is handed off, a pacing set by the three-step
// multiply and hold sequence of the lanes plus the hand-off into the output register.
// Reset: configuration returns to its defaults; phase, held samples and the
// peak meter clear to zero; no result is pending.
// ----------------------------------------------------------------------------
// stereo_bitcrusher_mix_top
// Sample-rate reduction and bit-depth quantiser with dry/wet mix, two lanes.
// ----------------------------------------------------------------------------
module stereo_bitcrusher_mix_top #(
  parameter int unsigned SampleBits = sbc_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sbc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SampleBits-1:0]      left_in_i,
  input  logic signed [SampleBits-1:0]      right_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SampleBits-1:0]      left_out_o,
  output logic signed [SampleBits-1:0]      right_out_o,
  output logic [sbc_pkg::PeakW-1:0]         peak_level_o
);

  logic                              bypass_q;
  logic                              mono_q;
  logic [sbc_pkg::LevelsW-1:0]       levels_q;
  logic [sbc_pkg::RecipW-1:0]        recip_q;
  logic [sbc_pkg::StepW-1:0]         step_q;
  logic [sbc_pkg::DryW-1:0]          dry_q;

  logic [sbc_pkg::StepW-1:0]         phase_q;
  logic [sbc_pkg::StepW-1:0]         phase_d;
  logic [sbc_pkg::StepW-1:0]         step_sat;
  logic [sbc_pkg::StepW-1:0]         phase_sum;
  logic                              wrap;
  logic                              crush;
  logic [sbc_pkg::DryW-1:0]          dry_sat;
  logic [sbc_pkg::DryW-1:0]          wet;
  logic [sbc_pkg::RwW-1:0]           rw_q;
  sbc_pkg::ctrl_t                    ctrl_q;

  sbc_pkg::state_e                   state_q;
  sbc_pkg::state_e                   state_d;
  sbc_pkg::lane_en_t                 lane_en;
  logic                              accept;
  logic                              done;
  logic                              merge_ready;

  logic signed [SampleBits-1:0]      x_l;
  logic signed [SampleBits-1:0]      x_r;
  logic signed [SampleBits-1:0]      mix_l;
  logic signed [SampleBits-1:0]      mix_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
      mono_q   <= 1'b0;
      levels_q <= sbc_pkg::LevelsReset;
      recip_q  <= sbc_pkg::RecipReset;
      step_q   <= sbc_pkg::StepReset;
      dry_q    <= '0;
    end else if (cfg_we_i) begin
      case (sbc_pkg::cfg_idx_e'(cfg_index_i))
        sbc_pkg::CFG_BYPASS: bypass_q <= cfg_data_i[0];
        sbc_pkg::CFG_MONO:   mono_q   <= cfg_data_i[0];
        sbc_pkg::CFG_LEVELS: levels_q <= cfg_data_i[sbc_pkg::LevelsW-1:0];
        sbc_pkg::CFG_RECIP:  recip_q  <= cfg_data_i[sbc_pkg::RecipW-1:0];
        sbc_pkg::CFG_STEP:   step_q   <= cfg_data_i[sbc_pkg::StepW-1:0];
        sbc_pkg::CFG_DRY:    dry_q    <= cfg_data_i[sbc_pkg::DryW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    crush     = !mono_q && !bypass_q;
    step_sat  = step_q[sbc_pkg::StepW-1] ? sbc_pkg::PhaseOne : step_q;
    phase_sum = phase_q + step_sat;
    wrap      = phase_sum[sbc_pkg::StepW-1];
    phase_d   = {1'b0, phase_sum[sbc_pkg::StepW-2:0]};
    dry_sat   = (dry_q > sbc_pkg::DryFull) ? sbc_pkg::DryFull : dry_q;
    wet       = sbc_pkg::DryFull - dry_sat;
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      ctrl_q  <= '0;
    end else if (accept) begin
      if (crush) begin
        phase_q <= phase_d;
      end
      ctrl_q <= '{crush: crush, upd: crush && wrap, mono: mono_q, bypass: bypass_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rw_q <= sbc_pkg::RwW'(recip_q) * sbc_pkg::RwW'(wet);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbc_pkg::ST_IDLE:  if (in_valid_i) state_d = sbc_pkg::ST_QUANT;
      sbc_pkg::ST_QUANT: state_d = sbc_pkg::ST_SCALE;
      sbc_pkg::ST_SCALE: state_d = sbc_pkg::ST_MIX;
      sbc_pkg::ST_MIX:   if (merge_ready) state_d = sbc_pkg::ST_IDLE;
      default:           state_d = sbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    lane_en.load  = 1'b0;
    lane_en.scale = 1'b0;
    lane_en.hold  = 1'b0;
    done          = 1'b0;
    case (state_q)
      sbc_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        lane_en.load = in_valid_i;
      end
      sbc_pkg::ST_QUANT: lane_en.scale = 1'b1;
      sbc_pkg::ST_SCALE: lane_en.hold  = ctrl_q.upd;
      sbc_pkg::ST_MIX:   done          = 1'b1;
      default: ;
    endcase
  end

  sbc_lane #(.SampleBits(SampleBits)) u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (lane_en),
    .x_i      (left_in_i),
    .levels_i (levels_q),
    .dry_i    (dry_sat),
    .rw_i     (rw_q),
    .x_o      (x_l),
    .mix_o    (mix_l)
  );

  sbc_lane #(.SampleBits(SampleBits)) u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (lane_en),
    .x_i      (right_in_i),
    .levels_i (levels_q),
    .dry_i    (dry_sat),
    .rw_i     (rw_q),
    .x_o      (x_r),
    .mix_o    (mix_r)
  );

  sbc_merge #(.SampleBits(SampleBits)) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_q),
    .peak_en_i    (accept && mono_q),
    .left_in_i    (left_in_i),
    .done_i       (done),
    .x_l_i        (x_l),
    .x_r_i        (x_r),
    .mix_l_i      (mix_l),
    .mix_r_i      (mix_r),
    .out_stall_i  (out_stall_i),
    .ready_o      (merge_ready),
    .out_valid_o  (out_valid_o),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .peak_level_o (peak_level_o)
  );

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == sbc_pkg::ST_QUANT))
    else $error("accepted request did not enter the quantise step");

  a_phase_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q[sbc_pkg::StepW-1])
    else $error("phase accumulator reached one without wrapping");

  a_hold_only_crush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_en.hold |-> (ctrl_q.crush && !ctrl_q.mono && !ctrl_q.bypass))
    else $error("held sample updated outside stereo processing");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !out_valid_o) |=> (out_valid_o && (state_q == sbc_pkg::ST_IDLE)))
    else $error("finished result not moved into the output register");
`endif

endmodule

// ===== tb/stereo_bitcrusher_mix_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_bitcrusher_mix_top_tb
// Drives stereo sample requests through the bitcrusher mix block under several
// register settings, idling and output stall patterns, predicts each result from a local
// model of the phase accumulator, quantiser, dry/wet mix and peak meter, and
// checks every returned result field by field in order.
// ----------------------------------------------------------------------------
module stereo_bitcrusher_mix_top_tb;

  localparam int     SampleBits    = sbc_pkg::SampleBitsDef;
  localparam longint SampleUnit    = longint'(1) << (SampleBits - 1);
  localparam longint SampleMax     = SampleUnit - 1;
  localparam longint SampleMin     = -SampleUnit;
  localparam int     ClkPeriod     = 8;
  localparam int     Latency       = 3;
  localparam int     WatchdogLimit = 5000;
  localparam int     ReportLimit   = 10;
  localparam int     NumPhases     = 12;
  localparam int     PhaseRequests = 120;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    sample_t                   left;
    sample_t                   right;
    logic [sbc_pkg::PeakW-1:0] peak;
  } mix_result_t;

  class crush_scoreboard;
    logic                        bypass;
    logic                        mono;
    logic [sbc_pkg::LevelsW-1:0] levels;
    logic [sbc_pkg::RecipW-1:0]  recip;
    logic [sbc_pkg::StepW-1:0]   step;
    logic [sbc_pkg::DryW-1:0]    dry;
    logic [sbc_pkg::StepW-1:0]   phase;
    longint                      held_left;
    longint                      held_right;
    logic [sbc_pkg::PeakW-1:0]   peak;
    mix_result_t                 pending_mix[$];
    int                          errors;

    function new();
      bypass     = 1'b0;
      mono       = 1'b0;
      levels     = sbc_pkg::LevelsReset;
      recip      = sbc_pkg::RecipReset;
      step       = sbc_pkg::StepReset;
      dry        = '0;
      phase      = '0;
      held_left  = 0;
      held_right = 0;
      peak       = '0;
      errors     = 0;
    endfunction

    function void write_reg(sbc_pkg::cfg_idx_e idx, logic [sbc_pkg::CfgDataW-1:0] data);
      case (idx)
        sbc_pkg::CFG_BYPASS: bypass = data[0];
        sbc_pkg::CFG_MONO:   mono   = data[0];
        sbc_pkg::CFG_LEVELS: levels = data[sbc_pkg::LevelsW-1:0];
        sbc_pkg::CFG_RECIP:  recip  = data[sbc_pkg::RecipW-1:0];
        sbc_pkg::CFG_STEP:   step   = data[sbc_pkg::StepW-1:0];
        sbc_pkg::CFG_DRY:    dry    = data[sbc_pkg::DryW-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > SampleMax) return SampleMax;
      if (v < SampleMin) return SampleMin;
      return v;
    endfunction

    function longint crush_lane(longint x, longint wet);
      longint q;
      q = (x * longint'(levels)) / SampleUnit;
      return clamp((q * longint'(recip) * wet) / 128);
    endfunction

    function int pending();
      return pending_mix.size();
    endfunction

    function void note_request(sample_t l, sample_t r);
      longint                    xl;
      longint                    xr;
      longint                    dry_v;
      longint                    wet;
      logic [sbc_pkg::StepW-1:0] inc;
      logic [sbc_pkg::PeakW:0]   mag;
      mix_result_t               res;
      xl = longint'(l);
      xr = longint'(r);
      if (mono) begin
        mag = (sbc_pkg::PeakW + 1)'(xl < 0 ? -xl : xl);
        if (mag > {1'b0, peak}) peak = mag[sbc_pkg::PeakW-1:0];
        res.left  = l;
        res.right = '0;
      end else if (bypass) begin
        res.left  = l;
        res.right = r;
      end else begin
        dry_v = (dry > sbc_pkg::DryFull) ? 128 : longint'(dry);
        wet   = 128 - dry_v;
        inc   = (step > sbc_pkg::PhaseOne) ? sbc_pkg::PhaseOne : step;
        phase = phase + inc;
        if (phase >= sbc_pkg::PhaseOne) begin
          phase      = phase - sbc_pkg::PhaseOne;
          held_left  = crush_lane(xl, wet);
          held_right = crush_lane(xr, wet);
        end
        res.left  = sample_t'(clamp(held_left + (xl * dry_v) / 128));
        res.right = sample_t'(clamp(held_right + (xr * dry_v) / 128));
      end
      res.peak = peak;
      pending_mix.push_back(res);
    endfunction

    function void check_result(sample_t l, sample_t r, logic [sbc_pkg::PeakW-1:0] p);
      mix_result_t want;
      if (pending_mix.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: unrequested result left %0d right %0d peak %0d", $time, l, r, p);
        return;
      end
      want = pending_mix.pop_front();
      if (want.left !== l || want.right !== r || want.peak !== p) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: mismatch exp %0d %0d %0d, got %0d %0d %0d",
                   $time, want.left, want.right, want.peak, l, r, p);
      end
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [sbc_pkg::CfgIdxW-1:0]   cfg_index_i = sbc_pkg::CFG_BYPASS;
  logic [sbc_pkg::CfgDataW-1:0]  cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  sample_t                       left_in_i   = '0;
  sample_t                       right_in_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  sample_t                       left_out_o;
  sample_t                       right_out_o;
  logic [sbc_pkg::PeakW-1:0]     peak_level_o;

  crush_scoreboard sb;
  int              send_idle_pct  = 0;
  int              stall_pct      = 0;
  int              quiet_cycles   = 0;

  stereo_bitcrusher_mix_top #(
    .SampleBits(SampleBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .peak_level_o (peak_level_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(left_out_o, right_out_o, peak_level_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("stereo_bitcrusher_mix_top test failed");
      $finish;
    end
  end

  task automatic set_pressure(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 62; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 62; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task automatic write_reg(sbc_pkg::cfg_idx_e idx, logic [sbc_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(logic byp, logic mon, logic [sbc_pkg::LevelsW-1:0] lv,
                               logic [sbc_pkg::RecipW-1:0] rc,
                               logic [sbc_pkg::StepW-1:0] st,
                               logic [sbc_pkg::DryW-1:0] dr);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    write_reg(sbc_pkg::CFG_BYPASS, sbc_pkg::CfgDataW'(byp));
    write_reg(sbc_pkg::CFG_MONO,   sbc_pkg::CfgDataW'(mon));
    write_reg(sbc_pkg::CFG_LEVELS, sbc_pkg::CfgDataW'(lv));
    write_reg(sbc_pkg::CFG_RECIP,  sbc_pkg::CfgDataW'(rc));
    write_reg(sbc_pkg::CFG_STEP,   sbc_pkg::CfgDataW'(st));
    write_reg(sbc_pkg::CFG_DRY,    sbc_pkg::CfgDataW'(dr));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_setting();
    logic [sbc_pkg::LevelsW-1:0] lv;
    logic [sbc_pkg::RecipW-1:0]  rc;
    logic [sbc_pkg::StepW-1:0]   st;
    logic [sbc_pkg::DryW-1:0]    dr;
    case ($urandom_range(5))
      0: lv = '0;
      1: lv = 1;
      2: lv = '1;
      3: lv = sbc_pkg::LevelsW'(1) << $urandom_range(16);
      default: lv = sbc_pkg::LevelsW'($urandom_range(65536, 1));
    endcase
    if (lv != 0 && $urandom_range(3) != 0)
      rc = sbc_pkg::RecipW'((SampleUnit + longint'(lv) / 2) / longint'(lv));
    else
      case ($urandom_range(2))
        0: rc = '1;
        1: rc = 128;
        default: rc = sbc_pkg::RecipW'($urandom);
      endcase
    case ($urandom_range(5))
      0: st = '0;
      1: st = sbc_pkg::PhaseOne;
      2: st = '1;
      3: st = sbc_pkg::StepW'($urandom_range(sbc_pkg::PhaseOne));
      4: st = sbc_pkg::StepW'($urandom_range(4096, 1));
      default: st = sbc_pkg::StepW'($urandom);
    endcase
    case ($urandom_range(4))
      0: dr = '0;
      1: dr = sbc_pkg::DryFull;
      2: dr = '1;
      3: dr = sbc_pkg::DryW'($urandom_range(255));
      default: dr = sbc_pkg::DryW'($urandom_range(128));
    endcase
    apply_setting($urandom_range(4) == 0, $urandom_range(4) == 0, lv, rc, st, dr);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return sample_t'(SampleMin);
      1: return sample_t'(SampleMax);
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(sample_t l, sample_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(l, r);
  endtask

  task automatic send_extremes();
    send_sample(sample_t'(SampleMin), sample_t'(SampleMax));
    send_sample(sample_t'(SampleMax), sample_t'(SampleMin));
    send_sample('0, '1);
    send_sample('1, sample_t'(1));
    send_sample(sample_t'(SampleMin / 2), sample_t'(SampleMax / 3));
    in_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pressure(0);
    send_extremes();
    apply_setting(1'b1, 1'b1, sbc_pkg::LevelsReset, sbc_pkg::RecipReset,
                  sbc_pkg::StepReset, '0);
    send_extremes();
    apply_setting(1'b1, 1'b0, sbc_pkg::LevelsReset, sbc_pkg::RecipReset,
                  sbc_pkg::StepReset, '0);
    send_extremes();
    apply_setting(1'b0, 1'b0, '1, '1, '1, 8'd1);
    send_extremes();
    apply_setting(1'b0, 1'b0, '0, sbc_pkg::RecipReset, sbc_pkg::PhaseOne >> 1, '1);
    send_extremes();

    for (int ph = 0; ph < NumPhases; ph++) begin
      random_setting();
      set_pressure(ph);
      for (int n = 0; n < PhaseRequests; n++)
        send_sample(pick_sample(), pick_sample());
      in_valid_i <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("stereo_bitcrusher_mix_top test passed");
    else
      $display("stereo_bitcrusher_mix_top test failed");
    $finish;
  end

endmodule
